/* src/pcms_pkg.sv */
// package for the placement clique matrix stamper
// holds beat types, request and status codes, store control struct
// no dependencies
package pcms_pkg;

    // fixed field widths
    localparam int NUM_W   = 16;
    localparam int COORD_W = 32;
    localparam int MAT_W   = 32;
    localparam int VEC_W   = 48;
    localparam int IDX_W   = 6;

    // default matrix dimension and stamp weight
    localparam int MATRIX_SIZE_DEF = 64;
    localparam int STAMP_WEIGHT    = 2;

    // request codes
    localparam logic [1:0] REQ_STAMP   = 2'd0;
    localparam logic [1:0] REQ_RD_MAT  = 2'd1;
    localparam logic [1:0] REQ_RD_VEC  = 2'd2;
    localparam logic [1:0] REQ_CLEAR   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BOTH_FIXED = 2'd1;
    localparam logic [1:0] ST_RANGE      = 2'd2;

    // store targets
    localparam logic [1:0] TGT_MAT = 2'd0;
    localparam logic [1:0] TGT_XV  = 2'd1;
    localparam logic [1:0] TGT_YV  = 2'd2;

    // input beat
    typedef struct packed {
        logic [1:0]                req_type;
        logic [NUM_W-1:0]          first_block_num;
        logic                      first_block_fixed;
        logic signed [COORD_W-1:0] first_block_x;
        logic signed [COORD_W-1:0] first_block_y;
        logic [NUM_W-1:0]          second_block_num;
        logic                      second_block_fixed;
        logic signed [COORD_W-1:0] second_block_x;
        logic signed [COORD_W-1:0] second_block_y;
        logic [IDX_W-1:0]          read_row;
        logic [IDX_W-1:0]          read_col;
    } t_req_beat;

    // result beat
    typedef struct packed {
        logic [1:0]              status;
        logic signed [MAT_W-1:0] matrix_value;
        logic signed [VEC_W-1:0] x_vector_value;
        logic signed [VEC_W-1:0] y_vector_value;
    } t_rsp_beat;

    // store port control
    typedef struct packed {
        logic       rd;
        logic       wr;
        logic       clr;
        logic       clr_vec;
        logic [1:0] target;
    } t_mem_ctl;

endpackage

/* src/placement_clique_matrix_stamper.sv */
// Clique-model connectivity matrix and right-hand vector builder.
// Request beats (valid/ready) carry one of: stamp a block pair, read a
// matrix entry, read the x/y vector entries of a row, or clear all stores.
// Every request returns exactly one result beat (valid/ready) with a status
// and the read values (zero unless a good read).
// The cfg channel (valid/ready, always ready) writes index_offset, the
// number subtracted from block numbers to get a row; write it while idle.
// From accept to result beat, a movable pair runs four read-modify-writes
// of the matrix memory, each a read state then a write state through the
// one adder; a fixed-movable pair runs three (diagonal, x, y); a read makes
// one registered store read; a rejected stamp goes straight to the result.
// A new request is taken the cycle after the result is loaded, not while a
// stamp, read or clear is still running.
// Clear walks every matrix entry one per cycle. The same sweep runs right
// after reset, during which no request is taken.
// A result waits in the output register while the receiver stalls; the
// next request is still taken and held finished until that register frees.
module placement_clique_matrix_stamper #(
    parameter int MATRIX_SIZE = pcms_pkg::MATRIX_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  pcms_pkg::t_req_beat        i_req,
    output logic                       o_rsp_valid,
    input  logic                       i_rsp_ready,
    output pcms_pkg::t_rsp_beat        o_rsp,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pcms_pkg::NUM_W-1:0] i_cfg_data
);
    import pcms_pkg::*;

    localparam int RW = $clog2(MATRIX_SIZE);

    logic [NUM_W-1:0] r_index_offset;
    logic             r_rsp_valid;
    t_rsp_beat        r_rsp;

    logic             done;
    logic             out_free;
    t_rsp_beat        seq_rsp;
    t_mem_ctl         ctl;
    logic [RW-1:0]    row;
    logic [RW-1:0]    col;
    logic [VEC_W-1:0] delta;
    logic [VEC_W-1:0] sum;
    logic [VEC_W-1:0] wdata;
    logic [MAT_W-1:0] mat_rdata;
    logic [VEC_W-1:0] x_rdata;
    logic [VEC_W-1:0] y_rdata;

    // offset register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_offset <= NUM_W'(1);
        end else if (i_cfg_valid) begin
            r_index_offset <= i_cfg_data;
        end
    end

    pcms_seq #(
        .MATRIX_SIZE (MATRIX_SIZE),
        .RW          (RW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_req_valid),
        .o_req_ready    (o_req_ready),
        .i_req          (i_req),
        .i_index_offset (r_index_offset),
        .o_done         (done),
        .i_out_free     (out_free),
        .o_rsp          (seq_rsp),
        .o_ctl          (ctl),
        .o_row          (row),
        .o_col          (col),
        .o_delta        (delta),
        .i_sum          (sum),
        .o_wdata        (wdata),
        .i_mat_rdata    (mat_rdata),
        .i_x_rdata      (x_rdata),
        .i_y_rdata      (y_rdata)
    );

    pcms_alu u_alu (
        .i_target    (ctl.target),
        .i_mat_rdata (mat_rdata),
        .i_x_rdata   (x_rdata),
        .i_y_rdata   (y_rdata),
        .i_delta     (delta),
        .o_sum       (sum)
    );

    pcms_store #(
        .MATRIX_SIZE (MATRIX_SIZE),
        .RW          (RW)
    ) u_store (
        .i_clk       (i_clk),
        .i_ctl       (ctl),
        .i_row       (row),
        .i_col       (col),
        .i_wdata     (wdata),
        .o_mat_rdata (mat_rdata),
        .o_x_rdata   (x_rdata),
        .o_y_rdata   (y_rdata)
    );

    // output register for the result beat
    assign out_free = !r_rsp_valid || i_rsp_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (done && out_free) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_rsp <= seq_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

/* src/pcms_store.sv */
// matrix and right-hand vector memories of the clique matrix stamper
// one port each, registered read data, clear writes zero
// depends on pcms_pkg
module pcms_store #(
    parameter int MATRIX_SIZE = pcms_pkg::MATRIX_SIZE_DEF,
    parameter int RW          = $clog2(MATRIX_SIZE)
) (
    input  logic                       i_clk,
    input  pcms_pkg::t_mem_ctl         i_ctl,
    input  logic [RW-1:0]              i_row,
    input  logic [RW-1:0]              i_col,
    input  logic [pcms_pkg::VEC_W-1:0] i_wdata,
    output logic [pcms_pkg::MAT_W-1:0] o_mat_rdata,
    output logic [pcms_pkg::VEC_W-1:0] o_x_rdata,
    output logic [pcms_pkg::VEC_W-1:0] o_y_rdata
);
    import pcms_pkg::*;

    localparam int MAT_DEPTH = MATRIX_SIZE * MATRIX_SIZE;
    localparam int MAT_AW    = $clog2(MAT_DEPTH);
    localparam logic [MAT_AW-1:0] NSZ = MAT_AW'(MATRIX_SIZE);

    logic [MAT_W-1:0] mem_mat [MAT_DEPTH];
    logic [VEC_W-1:0] mem_x   [MATRIX_SIZE];
    logic [VEC_W-1:0] mem_y   [MATRIX_SIZE];

    logic [MAT_W-1:0] r_mat_q;
    logic [VEC_W-1:0] r_x_q;
    logic [VEC_W-1:0] r_y_q;

    logic [MAT_AW-1:0] mat_addr;
    logic              mat_we;
    logic              x_we;
    logic              y_we;
    logic [MAT_W-1:0]  mat_wdata;
    logic [VEC_W-1:0]  vec_wdata;

    // row-major entry address
    assign mat_addr = MAT_AW'(i_row) * NSZ + MAT_AW'(i_col);

    // write enables, clear forces zero data
    assign mat_we    = i_ctl.clr | (i_ctl.wr & (i_ctl.target == TGT_MAT));
    assign x_we      = (i_ctl.clr & i_ctl.clr_vec) | (i_ctl.wr & (i_ctl.target == TGT_XV));
    assign y_we      = (i_ctl.clr & i_ctl.clr_vec) | (i_ctl.wr & (i_ctl.target == TGT_YV));
    assign mat_wdata = i_ctl.clr ? '0 : i_wdata[MAT_W-1:0];
    assign vec_wdata = i_ctl.clr ? '0 : i_wdata;

    // matrix memory
    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            mem_mat[mat_addr] <= mat_wdata;
        end
        if (i_ctl.rd && (i_ctl.target == TGT_MAT)) begin
            r_mat_q <= mem_mat[mat_addr];
        end
    end

    // vector memories, both read together
    always_ff @(posedge i_clk) begin
        if (x_we) begin
            mem_x[i_row] <= vec_wdata;
        end
        if (y_we) begin
            mem_y[i_row] <= vec_wdata;
        end
        if (i_ctl.rd && (i_ctl.target != TGT_MAT)) begin
            r_x_q <= mem_x[i_row];
            r_y_q <= mem_y[i_row];
        end
    end

    assign o_mat_rdata = r_mat_q;
    assign o_x_rdata   = r_x_q;
    assign o_y_rdata   = r_y_q;

endmodule

/* src/pcms_alu.sv */
// shared accumulate unit of the clique matrix stamper
// selects the operand read from the target store and adds the delta
// depends on pcms_pkg
module pcms_alu (
    input  logic [1:0]                 i_target,
    input  logic [pcms_pkg::MAT_W-1:0] i_mat_rdata,
    input  logic [pcms_pkg::VEC_W-1:0] i_x_rdata,
    input  logic [pcms_pkg::VEC_W-1:0] i_y_rdata,
    input  logic [pcms_pkg::VEC_W-1:0] i_delta,
    output logic [pcms_pkg::VEC_W-1:0] o_sum
);
    import pcms_pkg::*;

    logic [VEC_W-1:0] opnd;

    // operand select, matrix entry widened (upper bits dropped on write)
    always_comb begin
        case (i_target)
            TGT_MAT: opnd = {{(VEC_W-MAT_W){1'b0}}, i_mat_rdata};
            TGT_XV:  opnd = i_x_rdata;
            TGT_YV:  opnd = i_y_rdata;
            default: opnd = '0;
        endcase
    end

    // wrapping add
    assign o_sum = opnd + i_delta;

endmodule

/* src/pcms_seq.sv */
// sequencer of the clique matrix stamper
// decodes a request beat, steps read-modify-writes through the shared adder,
// sweeps the stores on clear; depends on pcms_pkg
module pcms_seq #(
    parameter int MATRIX_SIZE = pcms_pkg::MATRIX_SIZE_DEF,
    parameter int RW          = $clog2(MATRIX_SIZE)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    output logic                       o_req_ready,
    input  pcms_pkg::t_req_beat        i_req,
    input  logic [pcms_pkg::NUM_W-1:0] i_index_offset,
    output logic                       o_done,
    input  logic                       i_out_free,
    output pcms_pkg::t_rsp_beat        o_rsp,
    output pcms_pkg::t_mem_ctl         o_ctl,
    output logic [RW-1:0]              o_row,
    output logic [RW-1:0]              o_col,
    output logic [pcms_pkg::VEC_W-1:0] o_delta,
    input  logic [pcms_pkg::VEC_W-1:0] i_sum,
    output logic [pcms_pkg::VEC_W-1:0] o_wdata,
    input  logic [pcms_pkg::MAT_W-1:0] i_mat_rdata,
    input  logic [pcms_pkg::VEC_W-1:0] i_x_rdata,
    input  logic [pcms_pkg::VEC_W-1:0] i_y_rdata
);
    import pcms_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_OP_RD = 3'd2;
    localparam logic [2:0] S_OP_WR = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [RW-1:0]    LAST_IDX  = RW'(MATRIX_SIZE - 1);
    localparam logic [VEC_W-1:0] DELTA_POS = VEC_W'(STAMP_WEIGHT);
    localparam logic [VEC_W-1:0] DELTA_NEG = VEC_W'(0) - VEC_W'(STAMP_WEIGHT);

    logic [2:0]         r_state,   n_state;
    logic [RW-1:0]      r_sw_row,  n_sw_row;
    logic [RW-1:0]      r_sw_col,  n_sw_col;
    logic               r_clr_req, n_clr_req;
    logic [1:0]         r_op,      n_op;
    logic [1:0]         r_req_type, n_req_type;
    logic [1:0]         r_status,  n_status;
    logic               r_fixed,   n_fixed;
    logic [RW-1:0]      r_rowa,    n_rowa;
    logic [RW-1:0]      r_rowb,    n_rowb;
    logic [COORD_W-1:0] r_fx,      n_fx;
    logic [COORD_W-1:0] r_fy,      n_fy;

    logic [NUM_W:0]     diff1;
    logic [NUM_W:0]     diff2;
    logic               ok1;
    logic               ok2;
    logic               rd_row_oor;
    logic               rd_col_oor;
    logic               accept;

    logic [1:0]         op_target;
    logic [RW-1:0]      op_row;
    logic [RW-1:0]      op_col;
    logic [VEC_W-1:0]   op_delta;
    logic               op_last;

    // block number to matrix row
    assign diff1 = {1'b0, i_req.first_block_num} - {1'b0, i_index_offset};
    assign diff2 = {1'b0, i_req.second_block_num} - {1'b0, i_index_offset};
    assign ok1   = !diff1[NUM_W] && (diff1[NUM_W-1:0] < NUM_W'(MATRIX_SIZE));
    assign ok2   = !diff2[NUM_W] && (diff2[NUM_W-1:0] < NUM_W'(MATRIX_SIZE));

    // read index range
    assign rd_row_oor = int'(i_req.read_row) >= MATRIX_SIZE;
    assign rd_col_oor = int'(i_req.read_col) >= MATRIX_SIZE;

    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;

    // current read-modify-write step
    always_comb begin
        op_target = TGT_MAT;
        op_row    = r_rowa;
        op_col    = r_rowa;
        op_delta  = DELTA_POS;
        op_last   = 1'b0;
        if (r_fixed) begin
            op_last = (r_op == 2'd2);
            case (r_op)
                2'd1: begin
                    op_target = TGT_XV;
                    op_delta  = {{(VEC_W-COORD_W-1){r_fx[COORD_W-1]}}, r_fx, 1'b0};
                end
                2'd2: begin
                    op_target = TGT_YV;
                    op_delta  = {{(VEC_W-COORD_W-1){r_fy[COORD_W-1]}}, r_fy, 1'b0};
                end
                default: begin
                    op_target = TGT_MAT;
                end
            endcase
        end else begin
            // two diagonals, then the two cross entries
            op_last  = (r_op == 2'd3);
            op_row   = (r_op == 2'd1 || r_op == 2'd3) ? r_rowb : r_rowa;
            op_col   = (r_op == 2'd1 || r_op == 2'd2) ? r_rowb : r_rowa;
            op_delta = r_op[1] ? DELTA_NEG : DELTA_POS;
        end
    end

    // store port drive
    always_comb begin
        o_ctl   = '0;
        o_row   = r_rowa;
        o_col   = r_rowb;
        o_delta = op_delta;
        o_wdata = i_sum;
        case (r_state)
            S_CLEAR: begin
                o_ctl.clr     = 1'b1;
                o_ctl.clr_vec = (r_sw_col == '0);
                o_row         = r_sw_row;
                o_col         = r_sw_col;
            end
            S_OP_RD: begin
                o_ctl.rd     = 1'b1;
                o_ctl.target = op_target;
                o_row        = op_row;
                o_col        = op_col;
            end
            S_OP_WR: begin
                o_ctl.wr     = 1'b1;
                o_ctl.target = op_target;
                o_row        = op_row;
                o_col        = op_col;
            end
            S_RD: begin
                o_ctl.rd     = 1'b1;
                o_ctl.target = (r_req_type == REQ_RD_MAT) ? TGT_MAT : TGT_XV;
            end
            default: begin
                o_ctl = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_sw_row   = r_sw_row;
        n_sw_col   = r_sw_col;
        n_clr_req  = r_clr_req;
        n_op       = r_op;
        n_req_type = r_req_type;
        n_status   = r_status;
        n_fixed    = r_fixed;
        n_rowa     = r_rowa;
        n_rowb     = r_rowb;
        n_fx       = r_fx;
        n_fy       = r_fy;
        case (r_state)
            S_CLEAR: begin
                // row-major sweep, vectors cleared at the start of each row
                if (r_sw_col == LAST_IDX) begin
                    n_sw_col = '0;
                    n_sw_row = r_sw_row + RW'(1);
                    if (r_sw_row == LAST_IDX) begin
                        n_sw_row  = '0;
                        n_clr_req = 1'b0;
                        n_state   = r_clr_req ? S_DONE : S_IDLE;
                    end
                end else begin
                    n_sw_col = r_sw_col + RW'(1);
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_req_type = i_req.req_type;
                    n_status   = ST_OK;
                    n_op       = '0;
                    case (i_req.req_type)
                        REQ_STAMP: begin
                            if (i_req.first_block_fixed && i_req.second_block_fixed) begin
                                n_status = ST_BOTH_FIXED;
                                n_state  = S_DONE;
                            end else if (i_req.second_block_fixed) begin
                                n_fixed = 1'b1;
                                n_rowa  = diff1[RW-1:0];
                                n_rowb  = diff1[RW-1:0];
                                n_fx    = i_req.second_block_x;
                                n_fy    = i_req.second_block_y;
                                n_status = ok1 ? ST_OK : ST_RANGE;
                                n_state  = ok1 ? S_OP_RD : S_DONE;
                            end else if (i_req.first_block_fixed) begin
                                n_fixed = 1'b1;
                                n_rowa  = diff2[RW-1:0];
                                n_rowb  = diff2[RW-1:0];
                                n_fx    = i_req.first_block_x;
                                n_fy    = i_req.first_block_y;
                                n_status = ok2 ? ST_OK : ST_RANGE;
                                n_state  = ok2 ? S_OP_RD : S_DONE;
                            end else begin
                                n_fixed  = 1'b0;
                                n_rowa   = diff1[RW-1:0];
                                n_rowb   = diff2[RW-1:0];
                                n_status = (ok1 && ok2) ? ST_OK : ST_RANGE;
                                n_state  = (ok1 && ok2) ? S_OP_RD : S_DONE;
                            end
                        end
                        REQ_RD_MAT: begin
                            n_rowa   = RW'(i_req.read_row);
                            n_rowb   = RW'(i_req.read_col);
                            n_status = (rd_row_oor || rd_col_oor) ? ST_RANGE : ST_OK;
                            n_state  = (rd_row_oor || rd_col_oor) ? S_DONE : S_RD;
                        end
                        REQ_RD_VEC: begin
                            n_rowa   = RW'(i_req.read_row);
                            n_status = rd_row_oor ? ST_RANGE : ST_OK;
                            n_state  = rd_row_oor ? S_DONE : S_RD;
                        end
                        default: begin
                            n_clr_req = 1'b1;
                            n_sw_row  = '0;
                            n_sw_col  = '0;
                            n_state   = S_CLEAR;
                        end
                    endcase
                end
            end
            S_OP_RD: begin
                n_state = S_OP_WR;
            end
            S_OP_WR: begin
                if (op_last) begin
                    n_state = S_DONE;
                end else begin
                    n_op    = r_op + 2'd1;
                    n_state = S_OP_RD;
                end
            end
            S_RD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_sw_row  <= '0;
            r_sw_col  <= '0;
            r_clr_req <= 1'b0;
            r_op      <= '0;
        end else begin
            r_state   <= n_state;
            r_sw_row  <= n_sw_row;
            r_sw_col  <= n_sw_col;
            r_clr_req <= n_clr_req;
            r_op      <= n_op;
        end
    end

    // request payload registers
    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_status   <= n_status;
        r_fixed    <= n_fixed;
        r_rowa     <= n_rowa;
        r_rowb     <= n_rowb;
        r_fx       <= n_fx;
        r_fy       <= n_fy;
    end

    // result beat, value fields only on a good read
    assign o_done = (r_state == S_DONE);
    always_comb begin
        o_rsp.status         = r_status;
        o_rsp.matrix_value   = '0;
        o_rsp.x_vector_value = '0;
        o_rsp.y_vector_value = '0;
        if (r_status == ST_OK && r_req_type == REQ_RD_MAT) begin
            o_rsp.matrix_value = i_mat_rdata;
        end
        if (r_status == ST_OK && r_req_type == REQ_RD_VEC) begin
            o_rsp.x_vector_value = i_x_rdata;
            o_rsp.y_vector_value = i_y_rdata;
        end
    end

endmodule
